FILE: rtl/core/uer_pkg.sv
`default_nettype none

package uer_pkg;

  localparam int unsigned NumChannelsDefault = 4;

  localparam int unsigned ChanW    = 2;
  localparam int unsigned EchoW    = 4;
  localparam int unsigned TickW    = 8;
  localparam int unsigned CountW   = 16;
  localparam int unsigned TimeoutW = 13;
  localparam int unsigned SpeedW   = 9;
  localparam int unsigned DistW    = 14;

  // distance = floor(count * speed / 200) = floor(floor(count * speed / 8) / 25)
  // the divide by 25 is a multiply by ceil(2^27 / 25) and a shift by 27,
  // exact for every dividend below 2^22
  localparam int unsigned ProdW       = CountW + SpeedW;
  localparam int unsigned PreShift    = 3;
  localparam int unsigned HalvedW     = ProdW - PreShift;
  localparam int unsigned RecipW      = 23;
  localparam int unsigned RecipShift  = 27;
  localparam int unsigned RecipProdW  = HalvedW + RecipW;
  localparam int unsigned QuotW       = RecipProdW - RecipShift;
  localparam logic [RecipW-1:0] RecipMul = 23'd5368710;

  localparam logic [TickW-1:0]    TriggerTicksRst  = 8'd20;
  localparam logic [TickW-1:0]    TicksPerCountRst = 8'd10;
  localparam logic [TimeoutW-1:0] TimeoutRst       = 13'd3800;
  localparam logic [SpeedW-1:0]   SpeedRst         = 9'd346;

  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [DistW-1:0]  DistMax  = '1;

  typedef enum logic [1:0] {
    PhIdle,
    PhTrig,
    PhWait,
    PhMeas
  } phase_e;

  typedef enum logic [1:0] {
    RegTriggerTicks,
    RegTicksPerCount,
    RegTimeoutCounts,
    RegSoundSpeed
  } reg_idx_e;

  typedef struct packed {
    logic [TickW-1:0]    trigger_ticks;
    logic [TickW-1:0]    ticks_per_count;
    logic [TimeoutW-1:0] timeout_counts;
    logic [SpeedW-1:0]   sound_speed;
  } cfg_t;

  typedef struct packed {
    logic [EchoW-1:0] trig;
    logic             busy;
    logic             done;
    logic             tmo;
  } flags_t;

  typedef struct packed {
    flags_t            flags;
    logic [CountW-1:0] count;
  } step_t;

endpackage

`default_nettype wire

FILE: rtl/core/ultrasonic_echo_ranger.sv
`default_nettype none

// Four-channel ultrasonic echo-pulse rangefinder. Feed one item per 1 us tick
// on the slave stream: tuser is the start flag, tdata carries the requested
// channel and the four echo pin levels. A start (ignored while busy or for a
// channel at or above NumChannels) drives that channel's trigger line for
// trigger_ticks ticks, then the block waits for the echo to rise and counts
// units of ticks_per_count ticks while it stays high. On the tick the echo
// falls, the result item carries done, and the range in millimeters =
// floor(count * sound_speed / 200), or zero with timed_out when the count
// reached timeout_counts. Every item gives exactly one result item showing
// the state after that tick. Throughput is one item per clock while the
// master side takes results; one register per pipeline stage: input register,
// sequencer step, count-by-speed multiply, reciprocal multiply for the divide
// by 200, and the output register. Both stream sides may stall freely; the
// pipeline holds each stage until the next one frees. Registers sit on the APB
// port at byte addresses 0, 4, 8 and 12 and should be written only while no
// items are in flight.
module ultrasonic_echo_ranger #(
  parameter int unsigned NumChannels = uer_pkg::NumChannelsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [1:0] channel, [5:2] echo_levels, zero pad
  input  wire logic        s_axis_tuser,   // [0] action (start request)
  // master stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [3:0] trigger_lines, [4] busy_res,
                                           // [5] done_res, [6] timed_out,
                                           // [20:7] range_mm, zero pad
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  uer_pkg::cfg_t     cfg_q;
  uer_pkg::reg_idx_e reg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = uer_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_ticks   <= uer_pkg::TriggerTicksRst;
      cfg_q.ticks_per_count <= uer_pkg::TicksPerCountRst;
      cfg_q.timeout_counts  <= uer_pkg::TimeoutRst;
      cfg_q.sound_speed     <= uer_pkg::SpeedRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        uer_pkg::RegTriggerTicks:  cfg_q.trigger_ticks   <= pwdata[7:0];
        uer_pkg::RegTicksPerCount: cfg_q.ticks_per_count <= pwdata[7:0];
        uer_pkg::RegTimeoutCounts: cfg_q.timeout_counts  <= pwdata[12:0];
        uer_pkg::RegSoundSpeed:    cfg_q.sound_speed     <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      uer_pkg::RegTriggerTicks:  prdata = {24'd0, cfg_q.trigger_ticks};
      uer_pkg::RegTicksPerCount: prdata = {24'd0, cfg_q.ticks_per_count};
      uer_pkg::RegTimeoutCounts: prdata = {19'd0, cfg_q.timeout_counts};
      uer_pkg::RegSoundSpeed:    prdata = {23'd0, cfg_q.sound_speed};
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // pipeline flow control: a stage loads when it is empty or its item moves on
  // ---------------------------------------------------------------------------
  logic v0_q, v1_q, v2_q, v3_q, vo_q;
  logic rdy0, rdy1, rdy2, rdy3, rdyo;

  assign rdyo = !vo_q || m_axis_tready;
  assign rdy3 = !v3_q || rdyo;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;

  assign s_axis_tready = rdy0;
  assign m_axis_tvalid = vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= s_axis_tvalid;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdyo) vo_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 0: input register
  // ---------------------------------------------------------------------------
  logic                        in_action_q;
  logic [uer_pkg::ChanW-1:0]   in_chan_q;
  logic [uer_pkg::EchoW-1:0]   in_echo_q;

  always_ff @(posedge clk_i) begin
    if (rdy0 && s_axis_tvalid) begin
      in_action_q <= s_axis_tuser;
      in_chan_q   <= s_axis_tdata[1:0];
      in_echo_q   <= s_axis_tdata[5:2];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: measurement sequencer steps once per tick
  // ---------------------------------------------------------------------------
  uer_pkg::step_t step;
  uer_pkg::step_t s1_q;
  logic           seq_step;

  assign seq_step = rdy1 && v0_q;

  uer_seq #(
    .NumChannels (NumChannels)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (seq_step),
    .action_i      (in_action_q),
    .channel_i     (in_chan_q),
    .echo_levels_i (in_echo_q),
    .cfg_i         (cfg_q),
    .step_o        (step)
  );

  always_ff @(posedge clk_i) begin
    if (seq_step) begin
      s1_q <= step;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: count times speed of sound
  // ---------------------------------------------------------------------------
  uer_pkg::flags_t               s2_flags_q;
  logic [uer_pkg::ProdW-1:0]     prod_d, prod_q;

  assign prod_d = {{uer_pkg::SpeedW{1'b0}}, s1_q.count}
                * {{uer_pkg::CountW{1'b0}}, cfg_q.sound_speed};

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      s2_flags_q <= s1_q.flags;
      prod_q     <= prod_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: divide by 200 as a shift by 3 and a reciprocal multiply for 25
  // ---------------------------------------------------------------------------
  uer_pkg::flags_t                 s3_flags_q;
  logic [uer_pkg::RecipProdW-1:0]  recip_d;
  logic [uer_pkg::QuotW-1:0]       quot_q;

  assign recip_d = {{uer_pkg::RecipW{1'b0}}, prod_q[uer_pkg::ProdW-1:uer_pkg::PreShift]}
                 * {{uer_pkg::HalvedW{1'b0}}, uer_pkg::RecipMul};

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      s3_flags_q <= s2_flags_q;
      quot_q     <= recip_d[uer_pkg::RecipProdW-1:uer_pkg::RecipShift];
    end
  end

  // ---------------------------------------------------------------------------
  // output stage: saturate, hold the last distance, result register
  // ---------------------------------------------------------------------------
  uer_pkg::flags_t             out_flags_q;
  logic [uer_pkg::DistW-1:0]   out_dist_q;
  logic [uer_pkg::DistW-1:0]   last_dist_q;
  logic [uer_pkg::DistW-1:0]   dist_new;
  logic [uer_pkg::DistW-1:0]   dist_out;
  logic                        out_load;

  assign out_load = rdyo && v3_q;

  always_comb begin
    if (s3_flags_q.tmo) begin
      dist_new = '0;
    end else if (quot_q > {{(uer_pkg::QuotW-uer_pkg::DistW){1'b0}}, uer_pkg::DistMax}) begin
      dist_new = uer_pkg::DistMax;
    end else begin
      dist_new = quot_q[uer_pkg::DistW-1:0];
    end
    dist_out = s3_flags_q.done ? dist_new : last_dist_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_dist_q <= '0;
    end else if (out_load && s3_flags_q.done) begin
      last_dist_q <= dist_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_flags_q <= s3_flags_q;
      out_dist_q  <= dist_out;
    end
  end

  assign m_axis_tdata = {3'b000, out_dist_q, out_flags_q.tmo, out_flags_q.done,
                         out_flags_q.busy, out_flags_q.trig};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a finished measurement returns the sequencer to idle on the same tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && out_flags_q.done |-> !out_flags_q.busy)
    else $error("done reported while still busy");

  // timeout is only flagged together with done and always gives zero distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && out_flags_q.tmo |-> out_flags_q.done && (out_dist_q == '0))
    else $error("timeout without done or with nonzero distance");

  // at most one trigger line, and only while busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q |-> $onehot0(out_flags_q.trig) && (out_flags_q.busy || out_flags_q.trig == '0))
    else $error("bad trigger drive");

  // distance changes only on a done item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && !s3_flags_q.done |=> out_dist_q == $past(last_dist_q))
    else $error("distance changed without a finished measurement");

  // the sequencer steps only when stage 1 can take its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_step |-> v0_q && (!v1_q || rdy2))
    else $error("sequencer stepped on a stalled stage");

endmodule

`default_nettype wire

FILE: rtl/core/uer_seq.sv
`default_nettype none

module uer_seq #(
  parameter int unsigned NumChannels = uer_pkg::NumChannelsDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic                        action_i,
  input  wire logic [uer_pkg::ChanW-1:0]   channel_i,
  input  wire logic [uer_pkg::EchoW-1:0]   echo_levels_i,
  input  wire uer_pkg::cfg_t               cfg_i,
  output uer_pkg::step_t                   step_o
);

  uer_pkg::phase_e                phase_q, phase_d;
  logic [uer_pkg::ChanW-1:0]      chan_q, chan_d;
  logic [uer_pkg::TickW-1:0]      tick_q, tick_d;
  logic [uer_pkg::CountW-1:0]     count_q, count_d;
  logic [uer_pkg::TickW-1:0]      tick_inc;
  logic                           echo;
  logic                           chan_ok;
  logic                           done;
  logic                           tmo;

  assign tick_inc = tick_q + 8'd1;
  assign echo     = echo_levels_i[chan_q];
  assign chan_ok  = (int'(channel_i) < NumChannels);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= uer_pkg::PhIdle;
      chan_q  <= '0;
      tick_q  <= '0;
      count_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      chan_q  <= chan_d;
      tick_q  <= tick_d;
      count_q <= count_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    chan_d  = chan_q;
    tick_d  = tick_q;
    count_d = count_q;
    done    = 1'b0;
    tmo     = 1'b0;
    case (phase_q)
      uer_pkg::PhIdle: begin
        if (action_i && chan_ok) begin
          chan_d  = channel_i;
          tick_d  = 8'd1;
          phase_d = uer_pkg::PhTrig;
        end
      end
      uer_pkg::PhTrig: begin
        // a width of zero ends the pulse after one tick, like a width of one
        if (tick_q >= cfg_i.trigger_ticks) begin
          tick_d  = '0;
          phase_d = uer_pkg::PhWait;
        end else begin
          tick_d = tick_inc;
        end
      end
      uer_pkg::PhWait: begin
        if (echo) begin
          count_d = '0;
          tick_d  = '0;
          phase_d = uer_pkg::PhMeas;
        end
      end
      uer_pkg::PhMeas: begin
        if (echo) begin
          if (tick_inc >= cfg_i.ticks_per_count) begin
            tick_d = '0;
            if (count_q != uer_pkg::CountMax) begin
              count_d = count_q + 16'd1;
            end
          end else begin
            tick_d = tick_inc;
          end
        end else begin
          done    = 1'b1;
          tmo     = (count_q >= {3'b000, cfg_i.timeout_counts});
          tick_d  = '0;
          phase_d = uer_pkg::PhIdle;
        end
      end
      default: begin
        phase_d = uer_pkg::PhIdle;
      end
    endcase
  end

  always_comb begin
    step_o.flags.trig = (phase_d == uer_pkg::PhTrig)
                        ? ({{(uer_pkg::EchoW-1){1'b0}}, 1'b1} << chan_d) : '0;
    step_o.flags.busy = (phase_d != uer_pkg::PhIdle);
    step_o.flags.done = done;
    step_o.flags.tmo  = tmo;
    step_o.count      = count_d;
  end

endmodule

`default_nettype wire
